@@ src/lcf_pkg.sv @@
// Shared types, constants and color tables for the LED color text frame encoder.
`timescale 1ns / 1ps
`default_nettype none
package lcf_pkg;

    localparam int LCF_LED_LIMIT   = 32;
    localparam int LCF_QUEUE_DEPTH = 4;

    localparam logic [7:0] LED_HEADER = 8'hE0;
    localparam logic [7:0] END_BYTE   = 8'hFF;
    localparam logic [7:0] START_BYTE = 8'h00;
    localparam logic [4:0] BRIGHT_MAX = 5'd31;
    localparam logic [7:0] BRIGHT_SAT = 8'd32;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_NAME   = 5'b00010,
        MODE_ZERO   = 5'b00100,
        MODE_HEX    = 5'b01000,
        MODE_BRIGHT = 5'b10000
    } t_mode;

    typedef enum logic [6:0] {
        HX_START    = 7'b0000001,
        HX_PLUS     = 7'b0000010,
        HX_LEAD0    = 7'b0000100,
        HX_PREFIX   = 7'b0001000,
        HX_DIGITS   = 7'b0010000,
        HX_BAD      = 7'b0100000,
        HX_RESOLVED = 7'b1000000
    } t_hex;

    typedef enum logic [3:0] {
        BR_START  = 4'b0001,
        BR_PLUS   = 4'b0010,
        BR_DIGITS = 4'b0100,
        BR_BAD    = 4'b1000
    } t_bright;

    typedef enum logic [2:0] {
        SEG_START = 3'b001,
        SEG_LED   = 3'b010,
        SEG_END   = 3'b100
    } t_seg;

    // One request from the front end: which byte groups to send and their payload.
    typedef struct packed {
        logic        start;
        logic        led;
        logic        fin;
        logic        err;
        logic [4:0]  bright;
        logic [23:0] rgb;
        logic [5:0]  count;
    } t_cmd;

    // Color names are stored with the first character in the highest used byte.
    function automatic logic [63:0] color_row(input logic [2:0] idx);
        logic [63:0] row;
        case (idx)
            3'd0:    row = 64'("red");
            3'd1:    row = 64'("green");
            3'd2:    row = 64'("blue");
            3'd3:    row = 64'("yellow");
            3'd4:    row = 64'("cyan");
            3'd5:    row = 64'("magenta");
            3'd6:    row = 64'("white");
            default: row = 64'("black");
        endcase
        return row;
    endfunction

    function automatic logic [3:0] color_len(input logic [2:0] idx);
        logic [3:0] len;
        case (idx)
            3'd0:    len = 4'd3;
            3'd1:    len = 4'd5;
            3'd2:    len = 4'd4;
            3'd3:    len = 4'd6;
            3'd4:    len = 4'd4;
            3'd5:    len = 4'd7;
            3'd6:    len = 4'd5;
            default: len = 4'd5;
        endcase
        return len;
    endfunction

    function automatic logic [23:0] color_rgb(input logic [2:0] idx);
        logic [23:0] rgb;
        case (idx)
            3'd0:    rgb = 24'hFF0000;
            3'd1:    rgb = 24'h00FF00;
            3'd2:    rgb = 24'h0000FF;
            3'd3:    rgb = 24'hFFFF00;
            3'd4:    rgb = 24'h00FFFF;
            3'd5:    rgb = 24'hFF00FF;
            3'd6:    rgb = 24'hFFFFFF;
            default: rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage
`default_nettype wire

@@ src/led_color_text_to_spi_frame_core.sv @@
// Throughput: one character accepted per cycle while the 4-entry request queue has room.
// Output: one frame byte per cycle while m_axis_tready holds the output free.
// The byte sequencer sets the sustained rate (up to 12 bytes for one character).
// A request's first byte passes the request queue and then the output register after its character is accepted.
// Reset: synchronous, active low; clears token state, LED count, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none
module led_color_text_to_spi_frame_core #(
    parameter int MAX_LED_COUNT = lcf_pkg::LCF_LED_LIMIT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] frame_byte, [13:8] led_total, rest zero
    output logic             m_axis_tlast,
    output logic             m_axis_tuser    // [0] no_led_error
);
    import lcf_pkg::*;

    logic       accept;
    logic       push;
    t_cmd       push_cmd;
    logic       q_full;
    logic       q_valid;
    t_cmd       q_cmd;
    logic       q_pop;
    logic [7:0] out_byte;
    logic [5:0] out_total;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    lcf_front #(
        .MAX_LED_COUNT(MAX_LED_COUNT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    lcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    lcf_back #(
        .MAX_LED_COUNT(MAX_LED_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (out_byte),
        .o_end     (m_axis_tlast),
        .o_err     (m_axis_tuser),
        .o_total   (out_total)
    );

    assign m_axis_tdata = {2'b00, out_total, out_byte};

endmodule
`default_nettype wire

@@ src/lcf_front.sv @@
// Front end: tokenizes the color text and turns it into frame requests.
`timescale 1ns / 1ps
`default_nettype none
module lcf_front #(
    parameter int MAX_LED_COUNT = lcf_pkg::LCF_LED_LIMIT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_char,
    input  wire logic        i_last,
    output logic             o_push,
    output lcf_pkg::t_cmd    o_cmd
);
    import lcf_pkg::*;

    localparam int LW = $clog2(MAX_LED_COUNT + 1);

    logic          r_start_sent, n_start_sent;
    logic [LW-1:0] r_leds, n_leds;
    t_mode         r_mode, n_mode;
    logic [3:0]    r_pos, n_pos;
    logic [7:0]    r_cand, n_cand;
    logic [31:0]   r_hacc, n_hacc;
    t_hex          r_hst, n_hst;
    logic [7:0]    r_bacc, n_bacc;
    t_bright       r_bst, n_bst;
    t_cmd          n_cmd;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

    // Returns {ok, rgb} for the color part of the current token.
    function automatic logic [24:0] resolve(input t_mode mode, input logic [7:0] cand,
                                            input logic [3:0] pos, input t_hex hst,
                                            input logic [31:0] hacc);
        logic        ok;
        logic [23:0] rgb;
        ok  = 1'b0;
        rgb = 24'd0;
        if (mode == MODE_NAME) begin
            for (int i = 0; i < 8; i++) begin
                if (!ok && cand[i] && color_len(3'(i)) == pos) begin
                    ok  = 1'b1;
                    rgb = color_rgb(3'(i));
                end
            end
        end else if (mode == MODE_HEX) begin
            if (hst == HX_LEAD0 || hst == HX_DIGITS) begin
                ok  = 1'b1;
                rgb = hacc[23:0];
            end
        end
        return {ok, rgb};
    endfunction

    always_comb begin
        logic          delim;
        logic [7:0]    lc;
        logic [4:0]    hd;
        logic          dig;
        logic [9:0]    bv;
        logic [24:0]   res;
        logic [3:0]    len;
        logic [2:0]    bidx;
        logic [63:0]   row;
        logic [4:0]    bright;
        logic [LW+5:0] cnt_ext;

        n_start_sent = r_start_sent;
        n_leds       = r_leds;
        n_mode       = r_mode;
        n_pos        = r_pos;
        n_cand       = r_cand;
        n_hacc       = r_hacc;
        n_hst        = r_hst;
        n_bacc       = r_bacc;
        n_bst        = r_bst;
        n_cmd        = '0;
        bright       = BRIGHT_MAX;

        delim = (i_char == " ") || (i_char == "\t") || (i_char == "\n");
        lc    = (i_char >= "A" && i_char <= "Z") ? i_char + 8'd32 : i_char;
        hd    = hex_digit(i_char);
        dig   = (i_char >= "0" && i_char <= "9");
        bv    = '0;
        res   = '0;
        len   = '0;
        bidx  = '0;
        row   = '0;

        if (!r_start_sent) begin
            n_cmd.start  = 1'b1;
            n_start_sent = 1'b1;
        end

        // Feed a non-delimiter character into the token state.
        if (!delim) begin
            if (n_mode == MODE_IDLE) begin
                if (i_char == "#") begin
                    n_mode = MODE_HEX;
                end else if (i_char == "0") begin
                    n_mode = MODE_ZERO;
                    n_pos  = 4'd1;
                    n_cand = 8'd0;
                end else begin
                    n_mode = MODE_NAME;
                end
                lc = (n_mode == MODE_NAME) ? lc : lc;
            end
            if (r_mode == MODE_IDLE && n_mode != MODE_NAME) begin
                // The opening '#' or '0' of a token is fully consumed above.
            end else if (n_mode == MODE_BRIGHT) begin
                if (n_bst == BR_START && i_char == "+") begin
                    n_bst = BR_PLUS;
                end else if (dig && (n_bst == BR_START || n_bst == BR_PLUS)) begin
                    n_bacc = i_char - "0";
                    n_bst  = BR_DIGITS;
                end else if (dig && n_bst == BR_DIGITS) begin
                    bv = ({2'b00, n_bacc} << 3) + ({2'b00, n_bacc} << 1)
                         + {2'b00, i_char - "0"};
                    n_bacc = (bv > {2'b00, BRIGHT_SAT}) ? BRIGHT_SAT : bv[7:0];
                end else begin
                    n_bst = BR_BAD;
                end
            end else if (i_char == ":") begin
                res    = resolve(n_mode, n_cand, n_pos, n_hst, n_hacc);
                n_hacc = {8'd0, res[23:0]};
                n_hst  = res[24] ? HX_RESOLVED : HX_BAD;
                n_mode = MODE_BRIGHT;
            end else if (n_mode == MODE_ZERO) begin
                if (i_char == "x") begin
                    n_mode = MODE_HEX;
                    n_hst  = HX_START;
                end else begin
                    n_mode = MODE_NAME;
                    n_cand = 8'd0;
                end
            end else if (n_mode == MODE_HEX) begin
                unique case (n_hst)
                    HX_START, HX_PLUS: begin
                        if (i_char == "+" && n_hst == HX_START) begin
                            n_hst = HX_PLUS;
                        end else if (i_char == "0") begin
                            n_hacc = 32'd0;
                            n_hst  = HX_LEAD0;
                        end else if (hd[4]) begin
                            n_hacc = {28'd0, hd[3:0]};
                            n_hst  = HX_DIGITS;
                        end else begin
                            n_hst = HX_BAD;
                        end
                    end
                    HX_LEAD0: begin
                        if (i_char == "x" || i_char == "X") begin
                            n_hst = HX_PREFIX;
                        end else if (hd[4]) begin
                            n_hacc = {28'd0, hd[3:0]};
                            n_hst  = HX_DIGITS;
                        end else begin
                            n_hst = HX_BAD;
                        end
                    end
                    HX_PREFIX: begin
                        if (hd[4]) begin
                            n_hacc = {28'd0, hd[3:0]};
                            n_hst  = HX_DIGITS;
                        end else begin
                            n_hst = HX_BAD;
                        end
                    end
                    HX_DIGITS: begin
                        if (hd[4] && n_hacc[31:28] == 4'd0) begin
                            n_hacc = {n_hacc[27:0], hd[3:0]};
                        end else begin
                            n_hst = HX_BAD;
                        end
                    end
                    default: begin
                        n_hst = HX_BAD;
                    end
                endcase
            end else begin
                for (int i = 0; i < 8; i++) begin
                    len  = color_len(3'(i));
                    row  = color_row(3'(i));
                    bidx = 3'(len - 4'd1 - n_pos);
                    if (n_pos >= len || row[{bidx, 3'b000} +: 8] != lc) begin
                        n_cand[i] = 1'b0;
                    end
                end
                if (n_pos != 4'd15) begin
                    n_pos = n_pos + 4'd1;
                end
            end
        end

        // A delimiter or the final character closes the open token.
        if ((delim || i_last) && n_mode != MODE_IDLE) begin
            if (n_mode == MODE_BRIGHT) begin
                if (n_bst == BR_DIGITS && n_bacc <= {3'd0, BRIGHT_MAX}) begin
                    bright = n_bacc[4:0];
                end
            end else begin
                res    = resolve(n_mode, n_cand, n_pos, n_hst, n_hacc);
                n_hacc = {8'd0, res[23:0]};
                n_hst  = res[24] ? HX_RESOLVED : HX_BAD;
            end
            if (n_hst == HX_RESOLVED && n_leds < LW'(MAX_LED_COUNT)) begin
                n_leds       = n_leds + 1'b1;
                n_cmd.led    = 1'b1;
                n_cmd.bright = bright;
                n_cmd.rgb    = n_hacc[23:0];
            end
            n_mode = MODE_IDLE;
            n_pos  = 4'd0;
            n_cand = 8'hFF;
            n_hacc = 32'd0;
            n_hst  = HX_START;
            n_bacc = {3'd0, BRIGHT_MAX};
            n_bst  = BR_START;
        end

        cnt_ext     = {6'd0, n_leds};
        n_cmd.count = cnt_ext[5:0];

        if (i_last) begin
            n_cmd.fin    = 1'b1;
            n_cmd.err    = (n_leds == '0);
            n_start_sent = 1'b0;
            n_leds       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_sent <= 1'b0;
            r_leds       <= '0;
            r_mode       <= MODE_IDLE;
            r_pos        <= 4'd0;
            r_cand       <= 8'hFF;
            r_hacc       <= 32'd0;
            r_hst        <= HX_START;
            r_bacc       <= {3'd0, BRIGHT_MAX};
            r_bst        <= BR_START;
        end else if (i_accept) begin
            r_start_sent <= n_start_sent;
            r_leds       <= n_leds;
            r_mode       <= n_mode;
            r_pos        <= n_pos;
            r_cand       <= n_cand;
            r_hacc       <= n_hacc;
            r_hst        <= n_hst;
            r_bacc       <= n_bacc;
            r_bst        <= n_bst;
        end
    end

    assign o_push = i_accept && (n_cmd.start || n_cmd.led || n_cmd.fin);
    assign o_cmd  = n_cmd;

endmodule
`default_nettype wire

@@ src/lcf_queue.sv @@
// Short request queue between the tokenizer and the byte sequencer.
`timescale 1ns / 1ps
`default_nettype none
module lcf_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  lcf_pkg::t_cmd    i_cmd,
    input  wire logic        i_pop,
    output logic             o_full,
    output logic             o_valid,
    output lcf_pkg::t_cmd    o_cmd
);
    import lcf_pkg::*;

    localparam int AW = $clog2(LCF_QUEUE_DEPTH);
    localparam int CW = $clog2(LCF_QUEUE_DEPTH + 1);

    t_cmd          r_mem [LCF_QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(LCF_QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(LCF_QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_full  = (r_cnt == CW'(LCF_QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

endmodule
`default_nettype wire

@@ src/lcf_back.sv @@
// Back end: expands each request into start, LED and end bytes on a registered output.
`timescale 1ns / 1ps
`default_nettype none
module lcf_back #(
    parameter int MAX_LED_COUNT = lcf_pkg::LCF_LED_LIMIT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  lcf_pkg::t_cmd    i_q_cmd,
    output logic             o_q_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_byte,
    output logic             o_end,
    output logic             o_err,
    output logic [5:0]       o_total
);
    import lcf_pkg::*;

    logic       r_busy;
    t_cmd       r_cmd;
    t_seg       r_seg;
    logic [1:0] r_idx;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic       r_err;
    logic [5:0] r_total;

    t_cmd       cur_cmd;
    t_seg       cur_seg;
    logic [1:0] cur_idx;
    logic       load;
    logic       more;
    t_seg       nxt_seg;
    logic [7:0] b_data;
    logic       b_end;
    logic       b_err;
    logic [5:0] b_total;

    always_comb begin
        cur_cmd = r_busy ? r_cmd : i_q_cmd;
        cur_idx = r_busy ? r_idx : 2'd0;
        if (r_busy) begin
            cur_seg = r_seg;
        end else if (i_q_cmd.start) begin
            cur_seg = SEG_START;
        end else if (i_q_cmd.led) begin
            cur_seg = SEG_LED;
        end else begin
            cur_seg = SEG_END;
        end

        load = (r_busy || i_q_valid) && (!r_valid || i_ready);

        more    = 1'b0;
        nxt_seg = SEG_END;
        unique case (cur_seg)
            SEG_START: begin
                b_data  = START_BYTE;
                b_end   = 1'b0;
                b_err   = 1'b0;
                b_total = 6'd0;
                more    = cur_cmd.led || cur_cmd.fin;
                nxt_seg = cur_cmd.led ? SEG_LED : SEG_END;
            end
            SEG_LED: begin
                case (cur_idx)
                    2'd0:    b_data = LED_HEADER | {3'd0, cur_cmd.bright};
                    2'd1:    b_data = cur_cmd.rgb[7:0];
                    2'd2:    b_data = cur_cmd.rgb[15:8];
                    default: b_data = cur_cmd.rgb[23:16];
                endcase
                b_end   = 1'b0;
                b_err   = 1'b0;
                b_total = cur_cmd.count;
                more    = cur_cmd.fin;
                nxt_seg = SEG_END;
            end
            default: begin
                b_data  = END_BYTE;
                b_end   = (cur_idx == 2'd3);
                b_err   = (cur_idx == 2'd3) && cur_cmd.err;
                b_total = cur_cmd.count;
            end
        endcase
    end

    assign o_q_pop = load && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_seg   <= SEG_START;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                if (cur_idx != 2'd3) begin
                    r_busy <= 1'b1;
                    r_seg  <= cur_seg;
                    r_idx  <= cur_idx + 2'd1;
                end else begin
                    r_busy <= more;
                    r_seg  <= nxt_seg;
                    r_idx  <= 2'd0;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd   <= cur_cmd;
            r_byte  <= b_data;
            r_end   <= b_end;
            r_err   <= b_err;
            r_total <= b_total;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_end   = r_end;
    assign o_err   = r_err;
    assign o_total = r_total;

    a_err_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_err) |-> r_end)
        else $error("error flag outside the last end byte");

    a_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_end) |-> (r_byte == END_BYTE))
        else $error("last frame byte is not an end byte");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((MAX_LED_COUNT > 63) || (int'(r_total) <= MAX_LED_COUNT)))
        else $error("LED count beyond its limit");

endmodule
`default_nettype wire
